@@ design/hack_instruction_line_encoder_assert.svh @@
// assertion helpers for the hack line encoder
`ifndef HACK_INSTRUCTION_LINE_ENCODER_ASSERT_SVH
`define HACK_INSTRUCTION_LINE_ENCODER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define HILE_ASSERT_IMPLY(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define HILE_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define HILE_ASSERT_IMPLY(lbl, clk, rst_n, pre, post, msg)
`define HILE_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)

`endif

`endif

@@ design/hile_pkg.sv @@
`default_nettype none

package hile_pkg;

    typedef logic [7:0]  char_t;
    typedef logic [15:0] word_t;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BAD_COMP   = 2'd1,
        STATUS_BAD_JUMP   = 2'd2,
        STATUS_BAD_NUMBER = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } num_phase_t;

    typedef struct packed {
        char_t ch;
        logic  last_char;
    } char_beat_t;

    typedef struct packed {
        logic            at_start;
        logic            addr_form;
        logic [2:0]      dest_bits;
        logic            seen_equal;
        logic            seen_semi;
        logic [2:0][7:0] comp_text;
        logic [2:0]      comp_len;
        logic [2:0][7:0] jump_text;
        logic [2:0]      jump_len;
        logic [31:0]     accum;
        num_phase_t      phase;
        logic            neg;
        logic            err;
    } parse_state_t;

    typedef struct packed {
        logic       hit;
        logic [5:0] code;
    } comp_hit_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] code;
    } jump_hit_t;

    localparam parse_state_t PARSE_IDLE = '{
        at_start:   1'b1,
        addr_form:  1'b0,
        dest_bits:  3'd0,
        seen_equal: 1'b0,
        seen_semi:  1'b0,
        comp_text:  24'd0,
        comp_len:   3'd0,
        jump_text:  24'd0,
        jump_len:   3'd0,
        accum:      32'd0,
        phase:      PH_SKIP,
        neg:        1'b0,
        err:        1'b0
    };

    localparam logic [2:0] COMP_LEN_FULL   = 3'd3;
    localparam logic [2:0] COMP_LEN_LONG   = 3'd4;
    localparam logic [2:0] COMP_LEN_BAD_EQ = 3'd7;
    localparam logic [2:0] JUMP_LEN_FULL   = 3'd3;
    localparam logic [2:0] JUMP_LEN_OVER   = 3'd4;

    localparam logic [2:0] DEST_A = 3'b100;
    localparam logic [2:0] DEST_D = 3'b010;
    localparam logic [2:0] DEST_M = 3'b001;

    localparam char_t CH_AT    = 8'h40;
    localparam char_t CH_EQ    = 8'h3D;
    localparam char_t CH_SEMI  = 8'h3B;
    localparam char_t CH_PLUS  = 8'h2B;
    localparam char_t CH_MINUS = 8'h2D;
    localparam char_t CH_SPACE = 8'h20;
    localparam char_t CH_TAB   = 8'h09;
    localparam char_t CH_CR    = 8'h0D;
    localparam char_t CH_ZERO  = 8'h30;
    localparam char_t CH_NINE  = 8'h39;
    localparam char_t CH_A     = 8'h41;
    localparam char_t CH_D     = 8'h44;
    localparam char_t CH_M     = 8'h4D;

    localparam logic [34:0] NUM_LIMIT_POS = 35'h07FFFFFFF;
    localparam logic [34:0] NUM_LIMIT_NEG = 35'h080000000;

    function automatic logic is_blank(input char_t c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input char_t c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // exact match against the comp mnemonics, only the first len chars count
    function automatic comp_hit_t comp_lookup(input char_t t0, input char_t t1,
                                              input char_t t2, input logic [2:0] len);
        comp_hit_t r;
        r.hit  = 1'b1;
        r.code = 6'd0;
        case (len)
            3'd1:
            begin
                case (t0)
                    "0":      r.code = 6'h2A;
                    "1":      r.code = 6'h3F;
                    "D":      r.code = 6'h0C;
                    "A", "M": r.code = 6'h30;
                    default:  r.hit  = 1'b0;
                endcase
            end
            3'd2:
            begin
                case ({t0, t1})
                    "-1":       r.code = 6'h3A;
                    "!D":       r.code = 6'h0D;
                    "!A", "!M": r.code = 6'h31;
                    "-D":       r.code = 6'h0F;
                    "-A", "-M": r.code = 6'h33;
                    default:    r.hit  = 1'b0;
                endcase
            end
            3'd3:
            begin
                case ({t0, t1, t2})
                    "D+1":        r.code = 6'h1F;
                    "A+1", "M+1": r.code = 6'h37;
                    "D-1":        r.code = 6'h0E;
                    "A-1", "M-1": r.code = 6'h32;
                    "D+A", "D+M": r.code = 6'h02;
                    "D-A", "D-M": r.code = 6'h13;
                    "A-D", "M-D": r.code = 6'h07;
                    "D&A", "D&M": r.code = 6'h00;
                    "D|A", "D|M": r.code = 6'h15;
                    default:      r.hit  = 1'b0;
                endcase
            end
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

    function automatic jump_hit_t jump_lookup(input char_t t0, input char_t t1,
                                              input char_t t2);
        jump_hit_t r;
        r.hit  = 1'b1;
        r.code = 3'd0;
        case ({t0, t1, t2})
            "JGT":   r.code = 3'd1;
            "JEQ":   r.code = 3'd2;
            "JGE":   r.code = 3'd3;
            "JLT":   r.code = 3'd4;
            "JNE":   r.code = 3'd5;
            "JLE":   r.code = 3'd6;
            "JMP":   r.code = 3'd7;
            default: r.hit  = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/hile_if.sv @@
`default_nettype none

interface hile_char_if;
    logic            valid;
    logic            ready;
    hile_pkg::char_t ch;
    logic            last_char;

    modport source (output valid, output ch, output last_char, input ready);
    modport sink   (input valid, input ch, input last_char, output ready);
endinterface

interface hile_word_if;
    logic            valid;
    logic            ready;
    hile_pkg::word_t word;
    logic [1:0]      status;

    modport source (output valid, output word, output status, input ready);
    modport sink   (input valid, input word, input status, output ready);
endinterface

`default_nettype wire

@@ design/hack_instruction_line_encoder.sv @@
// hack assembly line encoder: one character beat per cycle in, one word per line out
// a line end beat goes through the input register, then its result is registered
// throughput: one character per cycle; input register, parse logic and result register
// a line end waits only when the previous result has not been taken
// reset: rst_n asynchronous active low, clears parse state and both valid flags
`default_nettype none

module hack_instruction_line_encoder (
    input  wire logic   clk,
    input  wire logic   rst_n,
    hile_char_if.sink   line,
    hile_word_if.source instr
);
    import hile_pkg::*;

    logic       beat_valid;
    char_beat_t beat;
    logic       beat_take;

    hile_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .line       (line),
        .beat_valid (beat_valid),
        .beat       (beat),
        .beat_take  (beat_take)
    );

    hile_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat_valid (beat_valid),
        .beat       (beat),
        .beat_take  (beat_take),
        .instr      (instr)
    );

endmodule

`default_nettype wire

@@ design/hile_in_reg.sv @@
`default_nettype none

module hile_in_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    hile_char_if.sink             line,
    output logic                  beat_valid,
    output hile_pkg::char_beat_t  beat,
    input  wire logic             beat_take
);
    import hile_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    char_beat_t beat_reg;
    logic       accept;

    assign line.ready = !valid_reg || beat_take;
    assign accept     = line.valid && line.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (beat_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            beat_reg.ch        <= line.ch;
            beat_reg.last_char <= line.last_char;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

`default_nettype wire

@@ design/hile_core.sv @@
`default_nettype none

`include "hack_instruction_line_encoder_assert.svh"

module hile_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 beat_valid,
    input  wire hile_pkg::char_beat_t beat,
    output logic                      beat_take,
    hile_word_if.source               instr
);
    import hile_pkg::*;

    parse_state_t state_reg;
    parse_state_t state_next;
    parse_state_t s;
    logic         out_valid_reg;
    logic         out_valid_next;
    word_t        word_reg;
    word_t        word_next;
    status_t      status_reg;
    status_t      status_next;

    char_t        c;
    logic [34:0]  num_v;
    logic         num_over;
    comp_hit_t    comp_hit;
    jump_hit_t    jump_hit;
    logic         a_bit;
    logic [2:0]   jump_code;
    logic [2:0]   dest;
    logic         jump_bad;
    logic [14:0]  addr_val;

    // a line end may only be taken when the result register is free or being read out
    assign beat_take = beat_valid
        && (!beat.last_char || !out_valid_reg || instr.ready);
    assign c = beat.ch;

    // accum * 10 + digit
    assign num_v = ({3'd0, state_reg.accum} << 3) + ({3'd0, state_reg.accum} << 1)
        + {31'd0, c[3:0]};
    assign num_over = num_v > (state_reg.neg ? NUM_LIMIT_NEG : NUM_LIMIT_POS);

    always_comb
    begin
        s = state_reg;
        if (s.at_start && (c == CH_AT))
        begin
            s.addr_form = 1'b1;
        end
        else if (s.addr_form)
        begin
            case (s.phase)
                PH_SKIP:
                begin
                    if (!is_blank(c))
                    begin
                        if ((c == CH_PLUS) || (c == CH_MINUS))
                        begin
                            s.neg   = s.neg || (c == CH_MINUS);
                            s.phase = PH_SIGN;
                        end
                        else if (is_digit(c))
                        begin
                            if (!s.err)
                            begin
                                if (num_over)
                                    s.err = 1'b1;
                                else
                                    s.accum = num_v[31:0];
                            end
                            s.phase = PH_DIGITS;
                        end
                        else
                        begin
                            s.err   = 1'b1;
                            s.phase = PH_DONE;
                        end
                    end
                end
                PH_SIGN, PH_DIGITS:
                begin
                    if (is_digit(c))
                    begin
                        if (!s.err)
                        begin
                            if (num_over)
                                s.err = 1'b1;
                            else
                                s.accum = num_v[31:0];
                        end
                        s.phase = PH_DIGITS;
                    end
                    else
                    begin
                        // a sign with no digit after it is an error
                        s.err   = s.err || (s.phase == PH_SIGN);
                        s.phase = PH_DONE;
                    end
                end
                default:
                begin
                    s.phase = PH_DONE;
                end
            endcase
        end
        else if (s.seen_semi)
        begin
            if ((c == CH_EQ) && !s.seen_equal)
                s.comp_len = COMP_LEN_BAD_EQ;
            if (s.jump_len < JUMP_LEN_FULL)
                s.jump_text[s.jump_len[1:0]] = c;
            if (s.jump_len < JUMP_LEN_OVER)
                s.jump_len = s.jump_len + 3'd1;
        end
        else if (c == CH_SEMI)
        begin
            s.seen_semi = 1'b1;
        end
        else if ((c == CH_EQ) && !s.seen_equal)
        begin
            s.seen_equal = 1'b1;
            s.comp_len   = 3'd0;
        end
        else
        begin
            if (!s.seen_equal)
            begin
                if (c == CH_A) s.dest_bits = s.dest_bits | DEST_A;
                if (c == CH_D) s.dest_bits = s.dest_bits | DEST_D;
                if (c == CH_M) s.dest_bits = s.dest_bits | DEST_M;
            end
            if (s.comp_len < COMP_LEN_FULL)
                s.comp_text[s.comp_len[1:0]] = c;
            if (s.comp_len < COMP_LEN_LONG)
                s.comp_len = s.comp_len + 3'd1;
        end
        s.at_start = 1'b0;
    end

    // line finish, computed from the state after this beat
    always_comb
    begin
        comp_hit = comp_lookup(s.comp_text[0], s.comp_text[1], s.comp_text[2],
                               s.comp_len);
        jump_hit = jump_lookup(s.jump_text[0], s.jump_text[1], s.jump_text[2]);
        a_bit = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            if ((3'(k) < s.comp_len) && (s.comp_text[k] == CH_M))
                a_bit = 1'b1;
        end
        jump_bad  = 1'b0;
        jump_code = 3'd0;
        if (s.seen_semi && (s.jump_len == JUMP_LEN_FULL))
        begin
            jump_bad  = !jump_hit.hit;
            jump_code = jump_hit.code;
        end
        dest     = s.seen_equal ? s.dest_bits : 3'd0;
        addr_val = s.neg ? (15'd0 - s.accum[14:0]) : s.accum[14:0];

        word_next   = 16'd0;
        status_next = STATUS_OK;
        if (s.addr_form)
        begin
            if ((s.phase == PH_SKIP) || (s.phase == PH_SIGN) || s.err)
                status_next = STATUS_BAD_NUMBER;
            else
                word_next = {1'b0, addr_val};
        end
        else if (!comp_hit.hit)
        begin
            status_next = STATUS_BAD_COMP;
        end
        else if (jump_bad)
        begin
            status_next = STATUS_BAD_JUMP;
        end
        else
        begin
            word_next = {3'b111, a_bit, comp_hit.code, dest, jump_code};
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (instr.ready)
            out_valid_next = 1'b0;
        if (beat_take)
        begin
            if (beat.last_char)
            begin
                state_next     = PARSE_IDLE;
                out_valid_next = 1'b1;
            end
            else
            begin
                state_next = s;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= PARSE_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat_take && beat.last_char)
        begin
            word_reg   <= word_next;
            status_reg <= status_next;
        end
    end

    assign instr.valid  = out_valid_reg;
    assign instr.word   = word_reg;
    assign instr.status = status_reg;

    `HILE_ASSERT_IMPLY(a_err_word_zero, clk, rst_n, out_valid_reg && (status_reg != STATUS_OK), word_reg == 16'd0, "error result carries a nonzero word")
    `HILE_ASSERT_NEXT(a_line_end_result, clk, rst_n, beat_take && beat.last_char, out_valid_reg, "line end gave no result")
    `HILE_ASSERT_NEXT(a_line_end_clear, clk, rst_n, beat_take && beat.last_char, state_reg.at_start && !state_reg.addr_form && (state_reg.comp_len == 3'd0), "parse state not cleared after line end")
    `HILE_ASSERT_IMPLY(a_c_form_prefix, clk, rst_n, out_valid_reg && word_reg[15], word_reg[14:13] == 2'b11, "c instruction without 111 prefix")

endmodule

`default_nettype wire
